// ===== design/ialu_pkg.sv =====
// ----------------------------------------------------------------------------
// ialu_pkg
// Operation codes, widths and stage control types for the integer ALU.
// ----------------------------------------------------------------------------
package ialu_pkg;

   localparam int unsigned DataWidthDefault = 32;
   localparam int unsigned OpWidth = 5;

   typedef enum logic [OpWidth-1:0] {
      OP_ADD  = 5'd0,
      OP_SUB  = 5'd1,
      OP_MUL  = 5'd2,
      OP_DIV  = 5'd3,
      OP_LT   = 5'd4,
      OP_LE   = 5'd5,
      OP_GT   = 5'd6,
      OP_GE   = 5'd7,
      OP_EQ   = 5'd8,
      OP_LAND = 5'd9,
      OP_LOR  = 5'd10,
      OP_LXOR = 5'd11,
      OP_LNOT = 5'd12,
      OP_BAND = 5'd13,
      OP_BOR  = 5'd14,
      OP_BXOR = 5'd15,
      OP_BNOT = 5'd16,
      OP_SHL  = 5'd17,
      OP_SHR  = 5'd18
   } op_type;

   // flags that ride with every item through the divider lane
   typedef struct packed {
      logic is_div;
      logic div_zero;
      logic negate;
   } div_ctl_type;

endpackage

// ===== design/ialu_divider.sv =====
// ----------------------------------------------------------------------------
// ialu_divider
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// side payload carried along; advances only when enable is high.
// ----------------------------------------------------------------------------
module ialu_divider
   import ialu_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = DataWidthDefault,
   parameter int unsigned SIDE_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   input  logic [SIDE_WIDTH-1:0] side_in,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic [SIDE_WIDTH-1:0] side_out
);

   logic [DATA_WIDTH-1:0] rem_ff [1:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] quo_ff [1:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] dvs_ff [1:DATA_WIDTH];
   logic [SIDE_WIDTH-1:0] side_ff [1:DATA_WIDTH];

   for (genvar s = 0; s < DATA_WIDTH; s++) begin : g_stage
      logic [DATA_WIDTH-1:0] rem_cur, quo_cur, dvs_cur;
      logic [SIDE_WIDTH-1:0] side_cur;
      logic [DATA_WIDTH:0]   trial;
      logic [DATA_WIDTH:0]   shifted;
      if (s == 0) begin : g_first
         assign rem_cur  = '0;
         assign quo_cur  = dividend;
         assign dvs_cur  = divisor;
         assign side_cur = side_in;
      end else begin : g_next
         assign rem_cur  = rem_ff[s];
         assign quo_cur  = quo_ff[s];
         assign dvs_cur  = dvs_ff[s];
         assign side_cur = side_ff[s];
      end
      always_comb begin
         shifted = {rem_cur, quo_cur[DATA_WIDTH-1]};
         trial   = shifted - {1'b0, dvs_cur};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            if (trial[DATA_WIDTH]) begin
               rem_ff[s+1] <= shifted[DATA_WIDTH-1:0];
            end else begin
               rem_ff[s+1] <= trial[DATA_WIDTH-1:0];
            end
            quo_ff[s+1]  <= {quo_cur[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
            dvs_ff[s+1]  <= dvs_cur;
            side_ff[s+1] <= side_cur;
         end
      end
   end

   assign quotient = quo_ff[DATA_WIDTH];
   assign side_out = side_ff[DATA_WIDTH];

endmodule

// ===== design/ialu_fast_ops.sv =====
// ----------------------------------------------------------------------------
// ialu_fast_ops
// Unit for every operation except divide: the selected result is registered,
// and the multiply product is registered on its own.
// ----------------------------------------------------------------------------
module ialu_fast_ops
   import ialu_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [OpWidth-1:0]    operation,
   input  logic [DATA_WIDTH-1:0] operand_a,
   input  logic [DATA_WIDTH-1:0] operand_b,
   output logic [DATA_WIDTH-1:0] result
);

   localparam int unsigned ShiftBits = $clog2(DATA_WIDTH);

   logic [DATA_WIDTH-1:0] logic_ff, logic_in;
   logic [DATA_WIDTH-1:0] prod_ff;
   logic                  is_mul_ff;
   logic                  ta, tb, lt, gt, big_shift;
   logic [ShiftBits-1:0]  amount;

   always_comb begin
      ta        = operand_a != '0;
      tb        = operand_b != '0;
      lt        = $signed(operand_a) < $signed(operand_b);
      gt        = $signed(operand_b) < $signed(operand_a);
      amount    = operand_b[ShiftBits-1:0];
      big_shift = operand_b >= DATA_WIDTH'(DATA_WIDTH);
      logic_in  = '0;
      unique case (operation)
         OP_ADD:  logic_in = operand_a + operand_b;
         OP_SUB:  logic_in = operand_a - operand_b;
         OP_LT:   logic_in[0] = lt;
         OP_LE:   logic_in[0] = ~gt;
         OP_GT:   logic_in[0] = gt;
         OP_GE:   logic_in[0] = ~lt;
         OP_EQ:   logic_in[0] = operand_a == operand_b;
         OP_LAND: logic_in[0] = ta & tb;
         OP_LOR:  logic_in[0] = ta | tb;
         OP_LXOR: logic_in[0] = ta ^ tb;
         OP_LNOT: logic_in[0] = ~ta;
         OP_BAND: logic_in = operand_a & operand_b;
         OP_BOR:  logic_in = operand_a | operand_b;
         OP_BXOR: logic_in = operand_a ^ operand_b;
         OP_BNOT: logic_in = ~operand_a;
         OP_SHL:  logic_in = big_shift ? '0 : operand_a << amount;
         OP_SHR:  logic_in = big_shift ? '0 : operand_a >> amount;
         default: logic_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         logic_ff  <= logic_in;
         prod_ff   <= operand_a * operand_b;
         is_mul_ff <= operation == OP_MUL;
      end
   end

   assign result = is_mul_ff ? prod_ff : logic_ff;

endmodule

// ===== design/integer_alu_with_compares.sv =====
// Requests pass the input register, the divider stages and the output register.
// Throughput: one request per cycle unless the result is stalled; the divider has one stage per quotient bit.
// The whole pipeline freezes while the result is stalled; a new request is
// taken whenever the output register is empty or being drained.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// integer_alu_with_compares
// Pipelined integer ALU (32-bit by default) with signed compares, logic ops and divide.
// ----------------------------------------------------------------------------
module integer_alu_with_compares
   import ialu_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // operation[4:0], operand_a, operand_b, zero fill
   input  logic [((OpWidth+2*DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // result_value, divide_error, zero fill
   output logic [((DATA_WIDTH+1+7)/8)*8-1:0] rsp_tdata
);

   localparam int unsigned Depth = DATA_WIDTH + 2;
   localparam int unsigned InW = ((OpWidth+2*DATA_WIDTH+7)/8)*8;
   localparam int unsigned OutW = ((DATA_WIDTH+1+7)/8)*8;
   localparam int unsigned SideW = DATA_WIDTH + 3 + 1;

   logic                  advance;
   logic [Depth-1:0]      valid_ff, valid_in;
   logic [OpWidth-1:0]    op_ff;
   logic [DATA_WIDTH-1:0] a_ff, b_ff;
   logic [DATA_WIDTH-1:0] ma, mb, fast_res, fast_q_ff, quotient;
   div_ctl_type           ctl, ctl_out;
   logic [SideW-1:0]      side_out;
   logic [DATA_WIDTH-1:0] final_val;

   // stall only when a result sits unaccepted
   assign advance    = ~valid_ff[Depth-1] | rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[Depth-1];

   always_comb begin
      valid_in = {valid_ff[Depth-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff <= req_tdata[OpWidth-1:0];
         a_ff  <= req_tdata[OpWidth +: DATA_WIDTH];
         b_ff  <= req_tdata[OpWidth+DATA_WIDTH +: DATA_WIDTH];
      end
   end

   always_comb begin
      ma           = a_ff[DATA_WIDTH-1] ? DATA_WIDTH'(-a_ff) : a_ff;
      mb           = b_ff[DATA_WIDTH-1] ? DATA_WIDTH'(-b_ff) : b_ff;
      ctl.is_div   = op_ff == OP_DIV;
      ctl.div_zero = b_ff == '0;
      ctl.negate   = a_ff[DATA_WIDTH-1] ^ b_ff[DATA_WIDTH-1];
   end

   ialu_fast_ops #(.DATA_WIDTH(DATA_WIDTH)) u_fast (
      .clock     (clock),
      .enable    (advance),
      .operation (op_ff),
      .operand_a (a_ff),
      .operand_b (b_ff),
      .result    (fast_res)
   );

   // fast result is registered again, then delayed alongside the divider lane
   always_ff @(posedge clock) begin
      if (advance) begin
         fast_q_ff <= fast_res;
      end
   end

   ialu_divider #(.DATA_WIDTH(DATA_WIDTH), .SIDE_WIDTH(SideW)) u_div (
      .clock    (clock),
      .enable   (advance),
      .dividend (ma),
      .divisor  (mb),
      .side_in  ({1'b0, ctl, a_ff}),
      .quotient (quotient),
      .side_out (side_out)
   );

   // fast results are DATA_WIDTH-2 stages younger; delay them to line up
   logic [DATA_WIDTH-1:0] fast_dly_ff [DATA_WIDTH-2];
   always_ff @(posedge clock) begin
      if (advance) begin
         fast_dly_ff[0] <= fast_q_ff;
         for (int i = 1; i < DATA_WIDTH-2; i++) begin
            fast_dly_ff[i] <= fast_dly_ff[i-1];
         end
      end
   end

   logic [DATA_WIDTH-1:0] res_ff;
   logic                  err_ff;

   always_comb begin
      ctl_out = side_out[DATA_WIDTH +: 3];
      if (!ctl_out.is_div) begin
         final_val = fast_dly_ff[DATA_WIDTH-3];
      end else if (ctl_out.div_zero) begin
         final_val = '0;
      end else begin
         final_val = ctl_out.negate ? DATA_WIDTH'(-quotient) : quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= final_val;
         err_ff <= ctl_out.is_div & ctl_out.div_zero;
      end
   end

   assign rsp_tdata = OutW'({err_ff, res_ff});

   logic unused_ok;
   assign unused_ok = ^{req_tdata[InW-1:OpWidth+2*DATA_WIDTH], side_out[SideW-1],
                        side_out[DATA_WIDTH-1:0]};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("not ready with empty output");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_tready && !req_tvalid |=> !valid_ff[0])
      else $error("bubble became valid");

endmodule

// ===== tb/tb_integer_alu_with_compares.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_alu_with_compares
// Directed and random requests through the ALU with a local result predictor
// and in-order comparison of every response.
// ----------------------------------------------------------------------------
module tb_integer_alu_with_compares;
   import ialu_pkg::*;

   localparam int W = 32;
   localparam int REQ_W = ((OpWidth + 2*W + 7) / 8) * 8;
   localparam int RSP_W = ((W + 1 + 7) / 8) * 8;
   localparam int MAX_CYCLES = 400000;

   typedef struct packed {
      logic [W-1:0] value;
      logic         div_err;
   } alu_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   alu_result_type expected_results[$];
   int errors = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   integer_alu_with_compares DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic alu_result_type compute_alu(logic [4:0] op, logic [W-1:0] a,
                                                  logic [W-1:0] b);
      alu_result_type r;
      logic [W-1:0] ma, mb, q;
      logic ta, tb;
      r = '0;
      ta = (a != 0);
      tb = (b != 0);
      case (op)
         OP_ADD: r.value = a + b;
         OP_SUB: r.value = a - b;
         OP_MUL: r.value = a * b;
         OP_DIV: begin
            if (b == 0) begin
               r.div_err = 1'b1;
            end else begin
               ma = a[W-1] ? -a : a;
               mb = b[W-1] ? -b : b;
               q = ma / mb;
               r.value = (a[W-1] != b[W-1]) ? -q : q;
            end
         end
         OP_LT: r.value = ($signed(a) < $signed(b)) ? 1 : 0;
         OP_LE: r.value = ($signed(a) <= $signed(b)) ? 1 : 0;
         OP_GT: r.value = ($signed(a) > $signed(b)) ? 1 : 0;
         OP_GE: r.value = ($signed(a) >= $signed(b)) ? 1 : 0;
         OP_EQ: r.value = (a == b) ? 1 : 0;
         OP_LAND: r.value = (ta && tb) ? 1 : 0;
         OP_LOR: r.value = (ta || tb) ? 1 : 0;
         OP_LXOR: r.value = (ta != tb) ? 1 : 0;
         OP_LNOT: r.value = ta ? 0 : 1;
         OP_BAND: r.value = a & b;
         OP_BOR: r.value = a | b;
         OP_BXOR: r.value = a ^ b;
         OP_BNOT: r.value = ~a;
         OP_SHL: r.value = (b < W) ? (a << b) : '0;
         OP_SHR: r.value = (b < W) ? (a >> b) : '0;
         default: r.value = '0;
      endcase
      return r;
   endfunction

   // valid stays high between back-to-back requests; only idle cycles drop it
   task automatic send_request(logic [4:0] op, logic [W-1:0] a, logic [W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_W-OpWidth-2*W){1'b0}}, b, a, op};
      expected_results.push_back(compute_alu(op, a, b));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [W-1:0] random_operand();
      case ($urandom_range(5))
         0: return 32'h8000_0000 + $urandom_range(3);
         1: return 32'h7fff_fffd + $urandom_range(2);
         2: return $urandom_range(40);
         3: return -$urandom_range(40);
         default: return $urandom;
      endcase
   endfunction

   // stall the response side while checking each accepted response
   always @(posedge clock) begin
      alu_result_type got, want;
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[W-1:0], rsp_tdata[W]};
         if (expected_results.size() == 0) begin
            $display("%0t unexpected response %h", $time, got);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got.value !== want.value)
               $display("%0t result_value expected %h actual %h", $time,
                        want.value, got.value);
            if (got.div_err !== want.div_err)
               $display("%0t divide_error expected %b actual %b", $time,
                        want.div_err, got.div_err);
            if (got !== want) errors++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic test_directed();
      logic [W-1:0] mn, mx;
      mn = 32'h8000_0000;
      mx = 32'h7fff_ffff;
      for (int op = OP_ADD; op <= OP_SHR; op++) begin
         send_request(5'(op), mn, mx);
      end
      send_request(OP_DIV, 32'd7, '0);
      send_request(OP_DIV, mn, '1);
      send_request(OP_DIV, -32'sd7, 32'd2);
      send_request(OP_SHL, '1, 32'd32);
      send_request(OP_SHR, '1, '1);
      send_request(OP_SHR, mn, 32'd31);
      send_request(5'd19, '1, '1);
      send_request(5'd31, '1, '1);
   endtask

   task automatic test_random(int count);
      logic [4:0] op;
      logic [W-1:0] b;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 19))
                                        : 5'($urandom_range(OP_SHR));
         b = random_operand();
         if ((op == OP_SHL || op == OP_SHR) && $urandom_range(1)) b = $urandom_range(33);
         if (op == OP_DIV && $urandom_range(7) == 0) b = '0;
         send_request(op, random_operand(), b);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 32;
      recv_idle_pct = 57;
      test_directed();
      test_random(460);
      send_idle_pct = 57;
      recv_idle_pct = 32;
      test_random(460);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(460);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (W + 10) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== integer_alu_with_compares.f =====
design/ialu_pkg.sv
design/ialu_divider.sv
design/ialu_fast_ops.sv
design/integer_alu_with_compares.sv
tb/tb_integer_alu_with_compares.sv
